// ----- src/iee_pkg.sv -----
// iee_pkg: shared types and constants of the ising energy evaluator
// no dependencies; used by the interfaces, controller, datapath and top level

package iee_pkg;

    // defaults for the top-level parameters
    localparam int MAX_SPINS_DEF   = 64;
    localparam int PARAM_WIDTH_DEF = 32;

    // fixed field widths
    localparam int OP_W     = 1;
    localparam int IDX_W    = 12;
    localparam int VAL_W    = 32;
    localparam int SPIN_W   = 64;
    localparam int ENERGY_W = 48;
    localparam int CFG_W    = 7;

    localparam logic [CFG_W-1:0] NUM_SPINS_RST = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUPLE,
        ST_FIELD,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic wr_en;       // load one parameter word
        logic load_spins;  // capture spin vector and clear accumulator
        logic rd_en;       // read one parameter for the running sum
        logic field_phase; // read is a local field, not a coupling
        logic load_out;    // move the negated sum to the output register
    } t_cmd;

endpackage

// ----- src/iee_if.sv -----
// iee_in_if / iee_out_if: valid-ready channels of the ising energy evaluator
// depends on iee_pkg for field widths

interface iee_in_if;
    logic                         valid;
    logic                         ready;
    logic [iee_pkg::OP_W-1:0]     op;
    logic [iee_pkg::IDX_W-1:0]    param_index;
    logic signed [iee_pkg::VAL_W-1:0] param_value;
    logic [iee_pkg::SPIN_W-1:0]   spins;

    modport source (output valid, op, param_index, param_value, spins, input ready);
    modport sink   (input valid, op, param_index, param_value, spins, output ready);
endinterface

interface iee_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [iee_pkg::ENERGY_W-1:0] energy;

    modport source (output valid, energy, input ready);
    modport sink   (input valid, energy, output ready);
endinterface

// ----- src/iee_ram.sv -----
// iee_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module iee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2080
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/iee_ctrl.sv -----
// iee_ctrl: sequencer that walks couplings then fields, config register, handshakes
// depends on iee_pkg; drives iee_dp through t_cmd

module iee_ctrl #(
    parameter int MAX_SPINS = iee_pkg::MAX_SPINS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [iee_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    input  logic [iee_pkg::OP_W-1:0]    i_op,
    input  logic [iee_pkg::IDX_W-1:0]   i_param_index,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output iee_pkg::t_cmd               o_cmd,
    output logic [$clog2(MAX_SPINS*(MAX_SPINS+1)/2)-1:0] o_wr_addr,
    output logic [$clog2(MAX_SPINS*(MAX_SPINS+1)/2)-1:0] o_rd_addr,
    output logic [$clog2(MAX_SPINS)-1:0] o_spin_i,
    output logic [$clog2(MAX_SPINS)-1:0] o_spin_j
);

    localparam int DEPTH = MAX_SPINS * (MAX_SPINS + 1) / 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_SPINS);
    localparam int NW    = $clog2(MAX_SPINS + 1);
    localparam int PRW   = 2 * NW + 1;
    localparam int CMPW  = (PRW > iee_pkg::IDX_W) ? PRW : iee_pkg::IDX_W;

    iee_pkg::t_state        r_state, n_state;
    logic [iee_pkg::CFG_W-1:0] r_num_spins;
    logic [AW-1:0]          r_addr, n_addr;
    logic [IW-1:0]          r_i, n_i;
    logic [IW-1:0]          r_j, n_j;
    logic                   r_out_valid, n_out_valid;

    logic [NW-1:0]          w_n;
    logic [IW-1:0]          w_nm1;
    logic [IW-1:0]          w_nm2;
    logic [PRW-1:0]         w_prod;
    logic [PRW-1:0]         w_nparams;
    logic                   w_accept;
    logic                   w_idx_ok;

    // active spin count, clamped into [2, MAX_SPINS]
    always_comb begin
        if (r_num_spins < iee_pkg::CFG_W'(2)) begin
            w_n = NW'(2);
        end else if (r_num_spins > iee_pkg::CFG_W'(MAX_SPINS)) begin
            w_n = NW'(MAX_SPINS);
        end else begin
            w_n = NW'(r_num_spins);
        end
    end

    assign w_nm1     = IW'(w_n - NW'(1));
    assign w_nm2     = IW'(w_n - NW'(2));
    assign w_prod    = PRW'(w_n) * (PRW'(w_n) + PRW'(1));
    assign w_nparams = w_prod >> 1;
    assign w_idx_ok  = CMPW'(i_param_index) < CMPW'(w_nparams);

    assign w_accept  = i_in_valid && (r_state == iee_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iee_pkg::ST_IDLE;
            r_num_spins <= iee_pkg::NUM_SPINS_RST;
            r_out_valid <= 1'b0;
            r_addr      <= '0;
            r_i         <= '0;
            r_j         <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_addr      <= n_addr;
            r_i         <= n_i;
            r_j         <= n_j;
            if (i_cfg_we) begin
                r_num_spins <= i_cfg_wdata;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_i         = r_i;
        n_j         = r_j;
        n_out_valid = r_out_valid;
        o_cmd       = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            iee_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_op == iee_pkg::OP_EVAL) begin
                        o_cmd.load_spins = 1'b1;
                        n_addr  = '0;
                        n_i     = '0;
                        n_j     = IW'(1);
                        n_state = iee_pkg::ST_COUPLE;
                    end else begin
                        o_cmd.wr_en = w_idx_ok;
                    end
                end
            end
            iee_pkg::ST_COUPLE: begin
                // couplings sit in pair order, so the address just counts up
                o_cmd.rd_en = 1'b1;
                n_addr      = r_addr + AW'(1);
                if (r_j == w_nm1) begin
                    if (r_i == w_nm2) begin
                        n_i     = '0;
                        n_state = iee_pkg::ST_FIELD;
                    end else begin
                        n_i = r_i + IW'(1);
                        n_j = r_i + IW'(2);
                    end
                end else begin
                    n_j = r_j + IW'(1);
                end
            end
            iee_pkg::ST_FIELD: begin
                // address has reached the field offset n(n-1)/2
                o_cmd.rd_en       = 1'b1;
                o_cmd.field_phase = 1'b1;
                n_addr            = r_addr + AW'(1);
                if (r_i == w_nm1) begin
                    n_state = iee_pkg::ST_DRAIN;
                end else begin
                    n_i = r_i + IW'(1);
                end
            end
            iee_pkg::ST_DRAIN: begin
                // last read word is added this cycle
                n_state = iee_pkg::ST_FINISH;
            end
            iee_pkg::ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = iee_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = iee_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == iee_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_wr_addr   = i_param_index[AW-1:0];
    assign o_rd_addr   = r_addr;
    assign o_spin_i    = r_i;
    assign o_spin_j    = r_j;

endmodule

// ----- src/iee_dp.sv -----
// iee_dp: parameter store, spin register, signed accumulator and output register
// depends on iee_pkg and iee_ram; commanded by iee_ctrl

module iee_dp #(
    parameter int MAX_SPINS   = iee_pkg::MAX_SPINS_DEF,
    parameter int PARAM_WIDTH = iee_pkg::PARAM_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  iee_pkg::t_cmd                     i_cmd,
    input  logic [$clog2(MAX_SPINS*(MAX_SPINS+1)/2)-1:0] i_wr_addr,
    input  logic [$clog2(MAX_SPINS*(MAX_SPINS+1)/2)-1:0] i_rd_addr,
    input  logic [$clog2(MAX_SPINS)-1:0]      i_spin_i,
    input  logic [$clog2(MAX_SPINS)-1:0]      i_spin_j,
    input  logic signed [iee_pkg::VAL_W-1:0]  i_param_value,
    input  logic [iee_pkg::SPIN_W-1:0]        i_spins,
    output logic signed [iee_pkg::ENERGY_W-1:0] o_energy
);

    localparam int DEPTH = MAX_SPINS * (MAX_SPINS + 1) / 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int ACC_W = iee_pkg::ENERGY_W;

    logic [MAX_SPINS-1:0]   r_spins;
    logic                   r_rd_vld;
    logic                   r_neg;
    logic [ACC_W-1:0]       r_acc;
    logic [ACC_W-1:0]       r_energy;

    logic [PARAM_WIDTH-1:0] w_wdata;
    logic [PARAM_WIDTH-1:0] w_rdata;
    logic [ACC_W-1:0]       w_term;
    logic                   w_neg;

    // keep low PARAM_WIDTH bits, or sign-extend when the store is wider
    assign w_wdata = PARAM_WIDTH'(i_param_value);

    iee_ram #(
        .WIDTH (PARAM_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (i_wr_addr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (AW'(i_rd_addr)),
        .o_rdata (w_rdata)
    );

    // coupling adds when both spins agree, field adds when the spin is +1
    assign w_neg  = i_cmd.field_phase ? !r_spins[i_spin_i]
                                      : (r_spins[i_spin_i] != r_spins[i_spin_j]);
    assign w_term = ACC_W'($signed(w_rdata));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg <= w_neg;
        if (i_cmd.load_spins) begin
            r_spins <= i_spins[MAX_SPINS-1:0];
            r_acc   <= '0;
        end else if (r_rd_vld) begin
            r_acc <= r_neg ? (r_acc - w_term) : (r_acc + w_term);
        end
        if (i_cmd.load_out) begin
            r_energy <= ACC_W'(0) - r_acc;
        end
    end

    assign o_energy = r_energy;

endmodule

// ----- src/ising_energy_evaluator.sv -----
// ising_energy_evaluator: top level, joins iee_ctrl and iee_dp to the item channels
// depends on iee_pkg, iee_if (iee_in_if, iee_out_if), iee_ctrl, iee_dp, iee_ram

// A write item loads one Q8.24 parameter word into the store in its accept cycle
// (ignored at or beyond n(n+1)/2) and gives no result. An evaluate item loads its
// result into the output register in the finish state, and the next item is taken
// once the controller is back in idle: the couplings and then the local fields are
// read one word per cycle through the single read port of the parameter memory and
// summed into a 48-bit register. Only one item is in work at a time; a result
// waiting in the output register does not hold off the next item, but a finished
// sum waits until that result has left. The store has no reset: every active entry
// must be written before an evaluation. num_spins may only be written while no
// item is in work.

module ising_energy_evaluator #(
    parameter int MAX_SPINS   = iee_pkg::MAX_SPINS_DEF,
    parameter int PARAM_WIDTH = iee_pkg::PARAM_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [iee_pkg::CFG_W-1:0] i_cfg_wdata,
    iee_in_if.sink                    i_in,
    iee_out_if.source                 o_out
);

    localparam int AW = $clog2(MAX_SPINS * (MAX_SPINS + 1) / 2);
    localparam int IW = $clog2(MAX_SPINS);

    iee_pkg::t_cmd w_cmd;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;
    logic [IW-1:0] w_spin_i;
    logic [IW-1:0] w_spin_j;

    iee_ctrl #(
        .MAX_SPINS (MAX_SPINS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in.valid),
        .i_op          (i_in.op),
        .i_param_index (i_in.param_index),
        .o_in_ready    (i_in.ready),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_cmd         (w_cmd),
        .o_wr_addr     (w_wr_addr),
        .o_rd_addr     (w_rd_addr),
        .o_spin_i      (w_spin_i),
        .o_spin_j      (w_spin_j)
    );

    iee_dp #(
        .MAX_SPINS   (MAX_SPINS),
        .PARAM_WIDTH (PARAM_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_wr_addr     (w_wr_addr),
        .i_rd_addr     (w_rd_addr),
        .i_spin_i      (w_spin_i),
        .i_spin_j      (w_spin_j),
        .i_param_value (i_in.param_value),
        .i_spins       (i_in.spins),
        .o_energy      (o_out.energy)
    );

endmodule
